>>> rtl/changeset_op_parser_top_macros.svh
// assertion helpers used by the checker file
`ifndef CHANGESET_OP_PARSER_TOP_MACROS_SVH
`define CHANGESET_OP_PARSER_TOP_MACROS_SVH

// clocked assertion with an active-low reset that disables it
`define COP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, on the block clock and reset
`define COP_ASSERT(lbl, prop, msg) `COP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/cop_pkg.sv
`default_nettype none

package cop_pkg;

  localparam int MAX_ATTRIBS = 8;
  localparam int NUMBER_BITS = 40;
  localparam int ATTRIB_BITS = 16;

  // attribute fill counter and queue sizing
  localparam int FILL_W     = $clog2(MAX_ATTRIBS + 1);
  localparam int ATTQ_AW    = $clog2(2 * MAX_ATTRIBS);
  localparam int ATTQ_DEPTH = 1 << ATTQ_AW;
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

  // result kinds
  localparam logic [1:0] KIND_ATTR   = 2'd0;
  localparam logic [1:0] KIND_OP     = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // opcodes
  localparam logic [1:0] OP_KEEP   = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_EMPTY_ATTR  = 3'd1;
  localparam logic [2:0] ERR_EMPTY_LINES = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR    = 3'd4;
  localparam logic [2:0] ERR_EMPTY_COUNT = 3'd5;
  localparam logic [2:0] ERR_TOO_MANY    = 3'd6;
  localparam logic [2:0] ERR_OVERFLOW    = 3'd7;

  // one queued job for the back end: an operation, a terminal result, or both
  typedef struct packed {
    logic                   has_op;
    logic [1:0]             op_code;
    logic [NUMBER_BITS-1:0] lines;
    logic [NUMBER_BITS-1:0] count;
    logic [FILL_W-1:0]      n_attr;
    logic                   has_term;
    logic [2:0]             err;
  } cop_cmd_t;

  typedef struct packed {
    logic cmd_full;
    logic attr_full;
  } cop_qstat_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [1:0]             op_code;
    logic [NUMBER_BITS-1:0] line_count;
    logic [NUMBER_BITS-1:0] char_count;
    logic [ATTRIB_BITS-1:0] attribute_number;
    logic [2:0]             error_code;
    logic                   last_of_run;
  } cop_result_t;

endpackage

`default_nettype wire

>>> rtl/cop_if.sv
`default_nettype none

interface cop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       final_byte;

  modport source (output valid, output byte_in, output final_byte, input ready);
  modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

interface cop_out_if;
  import cop_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [1:0]             op_code;
  logic [NUMBER_BITS-1:0] line_count;
  logic [NUMBER_BITS-1:0] char_count;
  logic [ATTRIB_BITS-1:0] attribute_number;
  logic [2:0]             error_code;
  logic                   last_of_run;

  modport source (output valid, output kind, output op_code, output line_count,
                  output char_count, output attribute_number, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input op_code, input line_count,
                input char_count, input attribute_number, input error_code,
                input last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/cop_front.sv
`default_nettype none

module cop_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cop_in_if.sink                           in_i,
  input  cop_pkg::cop_qstat_t              qstat_i,
  output logic                             cmd_push_o,
  output cop_pkg::cop_cmd_t                cmd_o,
  output logic                             attr_push_o,
  output logic [cop_pkg::ATTRIB_BITS-1:0]  attr_o
);
  import cop_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ATTR  = 2'd1;
  localparam logic [1:0] PH_LINES = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_BAR    = 8'h7c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  localparam int PROD_W = NUMBER_BITS + 6;

  logic [1:0]             phase_q, phase_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [NUMBER_BITS-1:0] acc_q, acc_d;
  logic [NUMBER_BITS-1:0] lines_q, lines_d;
  logic [1:0]             pop_q, pop_d;
  logic                   seen_q, seen_d;
  logic                   stop_q, stop_d;

  logic [7:0]        c;
  logic              is_num, is_low, is_dig, is_op;
  logic [1:0]        op_val;
  logic [5:0]        dval;
  logic [PROD_W-1:0] prod;
  logic              ovf_attr, ovf_num;
  logic              accept;
  logic              t_req, start_c, attr_push;
  logic [2:0]        t_code;
  cop_cmd_t          cmd;

  assign c      = in_i.byte_in;
  assign is_num = (c >= CH_0) && (c <= CH_9);
  assign is_low = (c >= CH_LA) && (c <= CH_LZ);
  assign is_dig = is_num || is_low;
  assign dval   = is_num ? 6'(c - CH_0) : 6'(c - CH_LA + LETTER_BASE);
  assign is_op  = (c == CH_EQ) || (c == CH_MINUS) || (c == CH_PLUS);
  assign op_val = (c == CH_EQ) ? OP_KEEP : ((c == CH_MINUS) ? OP_DELETE : OP_INSERT);

  // acc * 36 + d by shift and add, overflow seen in the top bits
  assign prod = PROD_W'({acc_q, 5'b00000}) + PROD_W'({acc_q, 2'b00}) + PROD_W'(dval);
  assign ovf_attr = |prod[PROD_W-1:ATTRIB_BITS];
  assign ovf_num  = |prod[PROD_W-1:NUMBER_BITS];

  assign in_i.ready = !qstat_i.cmd_full && !qstat_i.attr_full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d   = phase_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    lines_d   = lines_q;
    pop_d     = pop_q;
    seen_d    = seen_q;
    stop_d    = stop_q;
    cmd       = '0;
    attr_push = 1'b0;
    t_req     = 1'b0;
    t_code    = ERR_NONE;
    start_c   = 1'b0;

    if (!stop_q) begin
      case (phase_q)
        PH_ATTR: begin
          if (is_dig) begin
            if (ovf_attr) begin
              t_req  = 1'b1;
              t_code = ERR_OVERFLOW;
            end else begin
              acc_d  = prod[NUMBER_BITS-1:0];
              seen_d = 1'b1;
            end
          end else if (!seen_q) begin
            t_req  = 1'b1;
            t_code = ERR_EMPTY_ATTR;
          end else if (c == CH_DOLLAR) begin
            t_req = 1'b1;
          end else if ((c == CH_STAR) || (c == CH_BAR) || is_op) begin
            if (fill_q >= FILL_W'(MAX_ATTRIBS)) begin
              t_req  = 1'b1;
              t_code = ERR_TOO_MANY;
            end else begin
              attr_push = 1'b1;
              fill_d    = fill_q + FILL_W'(1);
              start_c   = 1'b1;
            end
          end else begin
            t_req  = 1'b1;
            t_code = ERR_BAD_CHAR;
          end
        end
        PH_LINES: begin
          if (is_dig) begin
            if (ovf_num) begin
              t_req  = 1'b1;
              t_code = ERR_OVERFLOW;
            end else begin
              acc_d  = prod[NUMBER_BITS-1:0];
              seen_d = 1'b1;
            end
          end else if (!seen_q) begin
            t_req  = 1'b1;
            t_code = ERR_EMPTY_LINES;
          end else if (c == CH_DOLLAR) begin
            t_req = 1'b1;
          end else if (is_op) begin
            lines_d = acc_q;
            start_c = 1'b1;
          end else begin
            t_req  = 1'b1;
            t_code = ERR_BAD_CHAR;
          end
        end
        PH_COUNT: begin
          if (is_dig) begin
            if (ovf_num) begin
              t_req  = 1'b1;
              t_code = ERR_OVERFLOW;
            end else begin
              acc_d  = prod[NUMBER_BITS-1:0];
              seen_d = 1'b1;
            end
          end else if (!seen_q) begin
            t_req  = 1'b1;
            t_code = ERR_EMPTY_COUNT;
          end else begin
            // count closed by this byte: emit the op, then reparse the byte
            cmd.has_op  = 1'b1;
            cmd.op_code = pop_q;
            cmd.lines   = lines_q;
            cmd.count   = acc_q;
            cmd.n_attr  = fill_q;
            phase_d     = PH_START;
            fill_d      = '0;
            acc_d       = '0;
            lines_d     = '0;
            pop_d       = OP_KEEP;
            seen_d      = 1'b0;
            start_c     = 1'b1;
          end
        end
        default: start_c = 1'b1;
      endcase

      if (start_c) begin
        if (c == CH_STAR) begin
          phase_d = PH_ATTR;
          seen_d  = 1'b0;
          acc_d   = '0;
        end else if (c == CH_BAR) begin
          phase_d = PH_LINES;
          seen_d  = 1'b0;
          acc_d   = '0;
        end else if (is_op) begin
          pop_d   = op_val;
          phase_d = PH_COUNT;
          seen_d  = 1'b0;
          acc_d   = '0;
        end else if (c == CH_DOLLAR) begin
          t_req = 1'b1;
        end else begin
          t_req  = 1'b1;
          t_code = ERR_BAD_CHAR;
        end
      end
    end

    // end of string while still parsing
    if (in_i.final_byte && !stop_q && !t_req) begin
      t_req = 1'b1;
      if (phase_d == PH_START) begin
        t_code = ERR_NONE;
      end else if ((phase_d == PH_COUNT) && seen_d) begin
        cmd.has_op  = 1'b1;
        cmd.op_code = pop_d;
        cmd.lines   = lines_d;
        cmd.count   = acc_d;
        cmd.n_attr  = fill_d;
        t_code      = ERR_NONE;
      end else if (!seen_d) begin
        if (phase_d == PH_ATTR) begin
          t_code = ERR_EMPTY_ATTR;
        end else if (phase_d == PH_LINES) begin
          t_code = ERR_EMPTY_LINES;
        end else begin
          t_code = ERR_EMPTY_COUNT;
        end
      end else begin
        t_code = ERR_TRUNCATED;
      end
    end

    if (t_req) begin
      cmd.has_term = 1'b1;
      cmd.err      = t_code;
      // without an op the pending attributes are thrown away
      if (!cmd.has_op) begin
        cmd.n_attr = fill_d;
      end
      phase_d = PH_START;
      fill_d  = '0;
      acc_d   = '0;
      lines_d = '0;
      pop_d   = OP_KEEP;
      seen_d  = 1'b0;
      stop_d  = 1'b1;
    end

    if (in_i.final_byte) begin
      phase_d = PH_START;
      fill_d  = '0;
      acc_d   = '0;
      lines_d = '0;
      pop_d   = OP_KEEP;
      seen_d  = 1'b0;
      stop_d  = 1'b0;
    end
  end

  assign cmd_push_o  = accept && (cmd.has_op || cmd.has_term);
  assign cmd_o       = cmd;
  assign attr_push_o = accept && attr_push;
  assign attr_o      = acc_q[ATTRIB_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      fill_q  <= '0;
      acc_q   <= '0;
      lines_q <= '0;
      pop_q   <= OP_KEEP;
      seen_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      acc_q   <= acc_d;
      lines_q <= lines_d;
      pop_q   <= pop_d;
      seen_q  <= seen_d;
      stop_q  <= stop_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cop_queue.sv
`default_nettype none

module cop_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_push_i,
  input  cop_pkg::cop_cmd_t                cmd_i,
  input  logic                             attr_push_i,
  input  logic [cop_pkg::ATTRIB_BITS-1:0]  attr_i,
  output cop_pkg::cop_qstat_t              qstat_o,
  output logic                             cmd_valid_o,
  output cop_pkg::cop_cmd_t                cmd_o,
  input  logic                             cmd_pop_i,
  output logic [cop_pkg::ATTRIB_BITS-1:0]  attr_o,
  input  logic [cop_pkg::FILL_W-1:0]       attr_pop_i
);
  import cop_pkg::*;

  localparam int CMD_CW = CMDQ_AW + 1;
  localparam int ATT_CW = ATTQ_AW + 1;

  cop_cmd_t               cmd_mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]     cmd_wr_q, cmd_rd_q;
  logic [CMD_CW-1:0]      cmd_cnt_q;

  logic [ATTRIB_BITS-1:0] attr_mem_q [ATTQ_DEPTH];
  logic [ATTQ_AW-1:0]     attr_wr_q, attr_rd_q;
  logic [ATT_CW-1:0]      attr_cnt_q;

  assign qstat_o.cmd_full  = (cmd_cnt_q == CMD_CW'(CMDQ_DEPTH));
  assign qstat_o.attr_full = (attr_cnt_q == ATT_CW'(ATTQ_DEPTH));
  assign cmd_valid_o       = (cmd_cnt_q != '0);
  assign cmd_o             = cmd_mem_q[cmd_rd_q];
  assign attr_o            = attr_mem_q[attr_rd_q];

  always_ff @(posedge clk_i) begin
    if (cmd_push_i) begin
      cmd_mem_q[cmd_wr_q] <= cmd_i;
    end
    if (attr_push_i) begin
      attr_mem_q[attr_wr_q] <= attr_i;
    end
  end

  // attribute pops may drop several entries at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_wr_q   <= '0;
      cmd_rd_q   <= '0;
      cmd_cnt_q  <= '0;
      attr_wr_q  <= '0;
      attr_rd_q  <= '0;
      attr_cnt_q <= '0;
    end else begin
      if (cmd_push_i) begin
        cmd_wr_q <= cmd_wr_q + CMDQ_AW'(1);
      end
      if (cmd_pop_i) begin
        cmd_rd_q <= cmd_rd_q + CMDQ_AW'(1);
      end
      cmd_cnt_q  <= cmd_cnt_q + CMD_CW'(cmd_push_i) - CMD_CW'(cmd_pop_i);
      if (attr_push_i) begin
        attr_wr_q <= attr_wr_q + ATTQ_AW'(1);
      end
      attr_rd_q  <= attr_rd_q + ATTQ_AW'(attr_pop_i);
      attr_cnt_q <= attr_cnt_q + ATT_CW'(attr_push_i) - ATT_CW'(attr_pop_i);
    end
  end

endmodule

`default_nettype wire

>>> rtl/cop_back.sv
`default_nettype none

module cop_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  cop_pkg::cop_cmd_t                cmd_i,
  output logic                             cmd_pop_o,
  input  logic [cop_pkg::ATTRIB_BITS-1:0]  attr_i,
  output logic [cop_pkg::FILL_W-1:0]       attr_pop_o,
  cop_out_if.source                        out_o
);
  import cop_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ATTR = 2'd1;
  localparam logic [1:0] ST_OP   = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0]        st_q, st_d;
  cop_cmd_t          cur_q, cur_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic              out_valid_q;
  cop_result_t       res_q, res;
  logic              can_emit, emit;

  assign can_emit = !out_valid_q || out_o.ready;

  always_comb begin
    st_d       = st_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    cmd_pop_o  = 1'b0;
    attr_pop_o = '0;
    emit       = 1'b0;
    res        = '0;
    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          if (cmd_i.has_op) begin
            rem_d = cmd_i.n_attr;
            st_d  = (cmd_i.n_attr != '0) ? ST_ATTR : ST_OP;
          end else begin
            // discarded prefix: drop its attributes in one go
            attr_pop_o = cmd_i.n_attr;
            st_d       = ST_TERM;
          end
        end
      end
      ST_ATTR: begin
        if (can_emit) begin
          emit                 = 1'b1;
          res.kind             = KIND_ATTR;
          res.attribute_number = attr_i;
          attr_pop_o           = FILL_W'(1);
          rem_d                = rem_q - FILL_W'(1);
          if (rem_q == FILL_W'(1)) begin
            st_d = ST_OP;
          end
        end
      end
      ST_OP: begin
        if (can_emit) begin
          emit            = 1'b1;
          res.kind        = KIND_OP;
          res.op_code     = cur_q.op_code;
          res.line_count  = cur_q.lines;
          res.char_count  = cur_q.count;
          res.last_of_run = !cur_q.has_term;
          st_d            = cur_q.has_term ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        if (can_emit) begin
          emit            = 1'b1;
          res.kind        = (cur_q.err == ERR_NONE) ? KIND_FINISH : KIND_ERROR;
          res.error_code  = cur_q.err;
          res.last_of_run = 1'b1;
          st_d            = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      rem_q <= rem_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      res_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.kind             = res_q.kind;
  assign out_o.op_code          = res_q.op_code;
  assign out_o.line_count       = res_q.line_count;
  assign out_o.char_count       = res_q.char_count;
  assign out_o.attribute_number = res_q.attribute_number;
  assign out_o.error_code       = res_q.error_code;
  assign out_o.last_of_run      = res_q.last_of_run;

endmodule

`default_nettype wire

>>> rtl/changeset_op_parser_top.sv
// Changeset operation tokenizer. Bytes of an operation string come in on in_i, one byte per
// handshake, final_byte on the last one; the grammar is (*attr)* [|lines] opcode count with
// lower-case base 36 numbers. Results leave on out_o: the attribute numbers of a finished
// operation, then the operation record, and a finished or error word where the string ends,
// hits a '$' or goes wrong; last_of_run flags the last word caused by one byte. The front
// parser takes one byte per cycle and only holds off while its 4-deep job queue or 16-deep
// attribute queue is full. The back end takes a job off the queue in its idle state and then
// sends the attribute words, the operation record and any terminal word in turn, holding while
// the registered output word is stalled; this draining limits the sustained throughput when
// operations are short. A result word passes through the job queue and the back end's idle
// state before it is registered at the output. Bytes after a finish or error are swallowed
// until final_byte.
`default_nettype none

module changeset_op_parser_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  cop_in_if.sink    in_i,
  cop_out_if.source out_o
);
  import cop_pkg::*;

  // front to queue
  logic                   cmd_push;
  cop_cmd_t               cmd_new;
  logic                   attr_push;
  logic [ATTRIB_BITS-1:0] attr_new;
  cop_qstat_t             qstat;

  // queue to back
  logic                   cmd_valid;
  cop_cmd_t               cmd_head;
  logic                   cmd_pop;
  logic [ATTRIB_BITS-1:0] attr_head;
  logic [FILL_W-1:0]      attr_pop;

  // parser: classifies each byte and queues jobs and attribute values
  cop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .qstat_i     (qstat),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_new),
    .attr_push_o (attr_push),
    .attr_o      (attr_new)
  );

  // decoupling queues, attribute values kept apart from the jobs
  cop_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_push_i  (cmd_push),
    .cmd_i       (cmd_new),
    .attr_push_i (attr_push),
    .attr_i      (attr_new),
    .qstat_o     (qstat),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_head),
    .cmd_pop_i   (cmd_pop),
    .attr_o      (attr_head),
    .attr_pop_i  (attr_pop)
  );

  // result sequencer with a registered output word
  cop_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .attr_i      (attr_head),
    .attr_pop_o  (attr_pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/cop_checker.sv
`default_nettype none
`include "changeset_op_parser_top_macros.svh"

module cop_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [1:0]                       kind_i,
  input logic [1:0]                       op_code_i,
  input logic [cop_pkg::NUMBER_BITS-1:0]  line_count_i,
  input logic [cop_pkg::NUMBER_BITS-1:0]  char_count_i,
  input logic [cop_pkg::ATTRIB_BITS-1:0]  attribute_number_i,
  input logic [2:0]                       error_code_i,
  input logic                             last_of_run_i
);
  import cop_pkg::*;

  // a stalled result word stays valid and keeps its kind, char count and attribute number
  `COP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(char_count_i) && $stable(attribute_number_i), "result word changed while stalled")

  // attribute words are never flagged last of their run
  `COP_ASSERT(a_attr_not_last, out_valid_i && kind_i == KIND_ATTR |-> !last_of_run_i, "attribute word flagged last")

  // finish and error always close a run
  `COP_ASSERT(a_term_last, out_valid_i && (kind_i == KIND_FINISH || kind_i == KIND_ERROR) |-> last_of_run_i, "terminal word not flagged last")

  // op fields are zero outside op words
  `COP_ASSERT(a_op_fields, out_valid_i && kind_i != KIND_OP |-> op_code_i == OP_KEEP && line_count_i == '0 && char_count_i == '0, "op fields set on non-op word")

  // error code present exactly on error words
  `COP_ASSERT(a_err_code, out_valid_i |-> (kind_i == KIND_ERROR) == (error_code_i != ERR_NONE), "error code mismatch")

endmodule

bind changeset_op_parser_top cop_checker u_cop_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .kind_i             (out_o.kind),
  .op_code_i          (out_o.op_code),
  .line_count_i       (out_o.line_count),
  .char_count_i       (out_o.char_count),
  .attribute_number_i (out_o.attribute_number),
  .error_code_i       (out_o.error_code),
  .last_of_run_i      (out_o.last_of_run)
);

`default_nettype wire

>>> bench/changeset_op_parser_top_tb.sv
`timescale 1ns / 1ps

module changeset_op_parser_top_tb;
  import cop_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 160;
  localparam int QUIET_FROM   = RANDOM_BYTES * 4 / 5;

  // characters of the grammar
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_BAR     = "|";
  localparam logic [7:0] CH_KEEP    = "=";
  localparam logic [7:0] CH_DEL     = "-";
  localparam logic [7:0] CH_INS     = "+";
  localparam logic [7:0] CH_DOLLAR  = "$";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";

  typedef enum logic [1:0] {PH_START, PH_ATTR, PH_LINES, PH_COUNT} parse_phase_e;

  logic clk;
  logic rst_n;

  cop_in_if  byte_if ();
  cop_out_if word_if ();

  changeset_op_parser_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_if),
    .out_o (word_if)
  );

  // sideband travelling with each byte: typed expectation for directed rows
  logic        drv_typed;
  logic        drv_first;
  cop_result_t drv_word;

  // tokenizer state as predicted
  parse_phase_e           phase_q = PH_START;
  logic [ATTRIB_BITS-1:0] attr_buf [MAX_ATTRIBS];
  int                     attr_fill;
  logic [63:0]            num_acc = '0;
  logic [NUMBER_BITS-1:0] lines_val = '0;
  logic [1:0]             pend_op = OP_KEEP;
  bit                     got_digit;
  bit                     swallowing;

  cop_result_t step_words[$];
  cop_result_t expected_words[$];

  string       row_text[$];
  bit          row_typed[$];
  cop_result_t row_word[$];
  logic [7:0]  rand_str[$];

  int mismatches;
  int cycle_count;
  bit idle_on = 1'b1;
  bit hold_out;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void add_word(logic [1:0] kind, logic [1:0] op,
                                   logic [NUMBER_BITS-1:0] lines,
                                   logic [NUMBER_BITS-1:0] count,
                                   logic [ATTRIB_BITS-1:0] attr, logic [2:0] err);
    cop_result_t w;
    w = '{kind: kind, op_code: op, line_count: lines, char_count: count,
          attribute_number: attr, error_code: err, last_of_run: 1'b0};
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void drop_prefix();
    phase_q   = PH_START;
    attr_fill = 0;
    num_acc   = '0;
    lines_val = '0;
    pend_op   = OP_KEEP;
    got_digit = 1'b0;
  endfunction

  // finish or error: bytes are swallowed until the final one
  function automatic void stop_with(logic [1:0] kind, logic [2:0] err);
    add_word(kind, OP_KEEP, '0, '0, '0, err);
    drop_prefix();
    swallowing = 1'b1;
  endfunction

  function automatic int digit_value(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + 10;
    return -1;
  endfunction

  function automatic int opcode_value(logic [7:0] c);
    if (c == CH_KEEP) return int'(OP_KEEP);
    if (c == CH_DEL) return int'(OP_DELETE);
    if (c == CH_INS) return int'(OP_INSERT);
    return -1;
  endfunction

  // base 36 digit into the accumulator, 0 when it no longer fits in bits
  function automatic bit add_digit(int d, int bits);
    logic [63:0] lim;
    lim = (64'd1 << bits) - 64'd1;
    if (num_acc > (lim - 64'(d)) / 64'd36) return 1'b0;
    num_acc   = num_acc * 64'd36 + 64'(d);
    got_digit = 1'b1;
    return 1'b1;
  endfunction

  function automatic void enter_phase(parse_phase_e ph);
    phase_q   = ph;
    got_digit = 1'b0;
    num_acc   = '0;
  endfunction

  // byte at an operation boundary or right after a complete prefix
  function automatic void open_item(logic [7:0] c);
    int op;
    op = opcode_value(c);
    if (c == CH_STAR) enter_phase(PH_ATTR);
    else if (c == CH_BAR) enter_phase(PH_LINES);
    else if (op >= 0) begin
      pend_op = 2'(op);
      enter_phase(PH_COUNT);
    end else if (c == CH_DOLLAR) stop_with(KIND_FINISH, ERR_NONE);
    else stop_with(KIND_ERROR, ERR_BAD_CHAR);
  endfunction

  function automatic void emit_op();
    for (int i = 0; i < attr_fill; i++)
      add_word(KIND_ATTR, OP_KEEP, '0, '0, attr_buf[i], ERR_NONE);
    add_word(KIND_OP, pend_op, lines_val, num_acc[NUMBER_BITS-1:0], '0, ERR_NONE);
    drop_prefix();
  endfunction

  function automatic void take_char(logic [7:0] c);
    int d;
    int op;
    d  = digit_value(c);
    op = opcode_value(c);
    case (phase_q)
      PH_ATTR: begin
        if (d >= 0) begin
          if (!add_digit(d, ATTRIB_BITS)) stop_with(KIND_ERROR, ERR_OVERFLOW);
        end else if (!got_digit) stop_with(KIND_ERROR, ERR_EMPTY_ATTR);
        else if (c == CH_DOLLAR) stop_with(KIND_FINISH, ERR_NONE);
        else if (c == CH_STAR || c == CH_BAR || op >= 0) begin
          if (attr_fill >= MAX_ATTRIBS) stop_with(KIND_ERROR, ERR_TOO_MANY);
          else begin
            attr_buf[attr_fill] = num_acc[ATTRIB_BITS-1:0];
            attr_fill++;
            open_item(c);
          end
        end else stop_with(KIND_ERROR, ERR_BAD_CHAR);
      end
      PH_LINES: begin
        if (d >= 0) begin
          if (!add_digit(d, NUMBER_BITS)) stop_with(KIND_ERROR, ERR_OVERFLOW);
        end else if (!got_digit) stop_with(KIND_ERROR, ERR_EMPTY_LINES);
        else if (c == CH_DOLLAR) stop_with(KIND_FINISH, ERR_NONE);
        else if (op >= 0) begin
          lines_val = num_acc[NUMBER_BITS-1:0];
          open_item(c);
        end else stop_with(KIND_ERROR, ERR_BAD_CHAR);
      end
      PH_COUNT: begin
        if (d >= 0) begin
          if (!add_digit(d, NUMBER_BITS)) stop_with(KIND_ERROR, ERR_OVERFLOW);
        end else if (!got_digit) stop_with(KIND_ERROR, ERR_EMPTY_COUNT);
        else begin
          // the byte that ends a count also opens the next operation
          emit_op();
          open_item(c);
        end
      end
      default: open_item(c);
    endcase
  endfunction

  function automatic void close_string();
    if (phase_q == PH_START) stop_with(KIND_FINISH, ERR_NONE);
    else if (phase_q == PH_COUNT && got_digit) begin
      emit_op();
      stop_with(KIND_FINISH, ERR_NONE);
    end else if (!got_digit) begin
      stop_with(KIND_ERROR, phase_q == PH_ATTR ? ERR_EMPTY_ATTR :
                            phase_q == PH_LINES ? ERR_EMPTY_LINES : ERR_EMPTY_COUNT);
    end else stop_with(KIND_ERROR, ERR_TRUNCATED);
  endfunction

  // words caused by one accepted byte, left in step_words
  function automatic void tokenize_byte(logic [7:0] c, logic fin);
    step_words.delete();
    if (!swallowing) take_char(c);
    if (fin) begin
      if (!swallowing) close_string();
      drop_prefix();
      swallowing = 1'b0;
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string word_text(cop_result_t w);
    return $sformatf("kind %0d op %0d lines %0d count %0d attr %0d err %0d last %0d",
                     w.kind, w.op_code, w.line_count, w.char_count,
                     w.attribute_number, w.error_code, w.last_of_run);
  endfunction

  function automatic void check_word(cop_result_t got);
    cop_result_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: stray word, expected none, actual %s", $time, word_text(got));
      mismatches++;
      return;
    end
    want = expected_words.pop_front();
    if (got !== want) begin
      $display("%0t: word mismatch, expected %s, actual %s", $time, word_text(want),
               word_text(got));
      mismatches++;
    end
  endfunction

  // byte side first so a same-edge word already has its expectation
  always @(posedge clk) begin
    if (byte_if.valid && byte_if.ready) begin
      tokenize_byte(byte_if.byte_in, byte_if.final_byte);
      if (!drv_typed) begin
        foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
      end else if (drv_first) begin
        expected_words.insert(expected_words.size(), drv_word);
      end
    end
    if (word_if.valid && word_if.ready) begin
      check_word('{kind: word_if.kind, op_code: word_if.op_code,
                   line_count: word_if.line_count, char_count: word_if.char_count,
                   attribute_number: word_if.attribute_number,
                   error_code: word_if.error_code, last_of_run: word_if.last_of_run});
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void typed_row(string text, logic [1:0] kind, logic [2:0] err);
    row_text.insert(row_text.size(), text);
    row_typed.insert(row_typed.size(), 1'b1);
    row_word.insert(row_word.size(),
                    '{kind: kind, op_code: OP_KEEP, line_count: '0, char_count: '0,
                      attribute_number: '0, error_code: err, last_of_run: 1'b1});
  endfunction

  function automatic void checked_row(string text);
    row_text.insert(row_text.size(), text);
    row_typed.insert(row_typed.size(), 1'b0);
    row_word.insert(row_word.size(), '0);
  endfunction

  function automatic void add_digits(int n);
    int d;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, 35);
      rand_str.insert(rand_str.size(),
                      d < 10 ? 8'(CH_ZERO + d) : 8'(CH_LOWER_A + d - 10));
    end
  endfunction

  // mostly well-formed strings, some with a corrupted, cut or missing byte
  function automatic void make_random_string();
    int         n_ops;
    int         n_attr;
    int         cut;
    logic [7:0] ops [3];
    ops = '{CH_KEEP, CH_DEL, CH_INS};
    rand_str.delete();
    n_ops = $urandom_range(1, 4);
    for (int k = 0; k < n_ops; k++) begin
      n_attr = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 3);
      for (int a = 0; a < n_attr; a++) begin
        rand_str.insert(rand_str.size(), CH_STAR);
        add_digits(($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3));
      end
      if ($urandom_range(0, 2) == 0) begin
        rand_str.insert(rand_str.size(), CH_BAR);
        add_digits(($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 3));
      end
      rand_str.insert(rand_str.size(), ops[$urandom_range(0, 2)]);
      add_digits(($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4));
    end
    if ($urandom_range(0, 2) == 0) begin
      rand_str.insert(rand_str.size(), CH_DOLLAR);
      // trailing junk gets swallowed
      repeat ($urandom_range(0, 2))
        rand_str.insert(rand_str.size(), 8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 7))
      0: rand_str[$urandom_range(0, rand_str.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        cut = $urandom_range(1, rand_str.size());
        while (rand_str.size() > cut) void'(rand_str.pop_back());
      end
      2: if (rand_str.size() > 1) rand_str.delete($urandom_range(0, rand_str.size() - 1));
      default: ;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] c, logic fin, bit typed, bit first,
                           cop_result_t word);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.byte_in    <= c;
    byte_if.final_byte <= fin;
    drv_typed          <= typed;
    drv_first          <= first;
    drv_word           <= word;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
  endtask

  // output side: random stalls, one long hold when asked
  initial begin
    forever begin
      if (hold_out && !hold_done) begin
        word_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        word_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        word_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("changeset_op_parser_top_tb: done, errors");
    $finish;
  end

  initial begin
    int random_sent;
    int strings_sent;
    rst_n              <= 1'b0;
    byte_if.valid      <= 1'b0;
    byte_if.byte_in    <= '0;
    byte_if.final_byte <= 1'b0;
    drv_typed          <= 1'b0;
    drv_first          <= 1'b0;
    drv_word           <= '0;

    // single-word strings: finish, every error code, dollar after a prefix
    typed_row("$", KIND_FINISH, ERR_NONE);
    typed_row("=", KIND_ERROR, ERR_EMPTY_COUNT);
    typed_row("*", KIND_ERROR, ERR_EMPTY_ATTR);
    typed_row("|", KIND_ERROR, ERR_EMPTY_LINES);
    typed_row("*5", KIND_ERROR, ERR_TRUNCATED);
    typed_row("|3", KIND_ERROR, ERR_TRUNCATED);
    typed_row("Z", KIND_ERROR, ERR_BAD_CHAR);
    typed_row("\377", KIND_ERROR, ERR_BAD_CHAR);
    typed_row("*=", KIND_ERROR, ERR_EMPTY_ATTR);
    typed_row("|*", KIND_ERROR, ERR_EMPTY_LINES);
    typed_row("-+", KIND_ERROR, ERR_EMPTY_COUNT);
    typed_row("*1ekg=1", KIND_ERROR, ERR_OVERFLOW);
    typed_row("*1*2*3*4*5*6*7*8*9=1", KIND_ERROR, ERR_TOO_MANY);
    typed_row("*1$", KIND_FINISH, ERR_NONE);
    typed_row("|2$", KIND_FINISH, ERR_NONE);
    typed_row("*1|2$", KIND_FINISH, ERR_NONE);
    typed_row("+zzzzzzzz", KIND_ERROR, ERR_OVERFLOW);
    typed_row("|zzzzzzzz=1", KIND_ERROR, ERR_OVERFLOW);
    typed_row("x*1=2", KIND_ERROR, ERR_BAD_CHAR);
    // multi-word strings, checked against the predictor
    checked_row("=0");
    checked_row("-e13wu1of");
    checked_row("|e13wu1of+1");
    checked_row("*1ekf=1");
    checked_row("*0*1*2*3*4*5*6*7|a=5+3-2$");
    checked_row("=1x");
    checked_row("=1*2");
    checked_row("=1-");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (row_text[i]) begin
      for (int j = 0; j < row_text[i].len(); j++)
        send_byte(row_text[i][j], j == row_text[i].len() - 1, row_typed[i], j == 0,
                  row_word[i]);
    end

    random_sent  = 0;
    strings_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      make_random_string();
      idle_on = (random_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      // long output hold while bytes keep coming, so the queues fill up
      if (strings_sent == 1) hold_out = 1'b1;
      foreach (rand_str[j]) begin
        if (random_sent >= QUIET_FROM) idle_on = 1'b0;
        send_byte(rand_str[j], j == rand_str.size() - 1, 1'b0, 1'b0, '0);
        random_sent++;
      end
      strings_sent++;
    end

    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("changeset_op_parser_top_tb: done, clean");
    else $display("changeset_op_parser_top_tb: done, errors");
    $finish;
  end

endmodule
